/* rtl/keypad_matrix_scan_debounce_defines.svh */
// assertion macros for the keypad scanner
// used by the top level, which carries the concurrent checks; needs nothing else
`ifndef KEYPAD_MATRIX_SCAN_DEBOUNCE_DEFINES_SVH
`define KEYPAD_MATRIX_SCAN_DEBOUNCE_DEFINES_SVH

// same-cycle implication, disabled while reset is high
`define KMSD_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("keypad scanner check failed");

// next-cycle implication, disabled while reset is high
`define KMSD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("keypad scanner check failed");

`endif

/* rtl/kmsd_pkg.sv */
// shared types and constants of the keypad scanner
// no dependencies
package kmsd_pkg;

  // default matrix size
  localparam int NUM_ROWS_DEF = 4;
  localparam int NUM_COLS_DEF = 3;

  // fixed payload widths
  localparam int SAMPLE_W = 3;
  localparam int KEYMAP_W = 12;
  localparam int ROW_W    = 2;
  localparam int DRIVE_W  = 4;

  // keys at this index and past it are never tracked
  localparam int MAX_KEYS = 64;

  typedef struct packed {
    logic [SAMPLE_W-1:0] column_sample;
    logic [KEYMAP_W-1:0] clear_keys;
    logic                clear_activity;
  } kmsd_in_t;

  typedef struct packed {
    logic [ROW_W-1:0]    scanned_row;
    logic [DRIVE_W-1:0]  next_row_drive;
    logic                new_press;
    logic [KEYMAP_W-1:0] pressed_keys;
    logic                any_activity;
  } kmsd_out_t;

  // row-side part of a result
  typedef struct packed {
    logic [ROW_W-1:0]   scanned_row;
    logic [DRIVE_W-1:0] next_row_drive;
  } kmsd_row_t;

  // key-side part of a result
  typedef struct packed {
    logic                new_press;
    logic [KEYMAP_W-1:0] pressed_keys;
    logic                any_activity;
  } kmsd_key_stat_t;

endpackage

/* rtl/kmsd_stream_if.sv */
// valid/ready stream channel with a typed payload
// payload types come from kmsd_pkg at the instance
interface kmsd_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/keypad_matrix_scan_debounce.sv */
// keypad matrix scanner with debounce, top level
// depends on kmsd_pkg, kmsd_stream_if, kmsd_row_seq, kmsd_debounce and the defines header
//
//  channel   dir  payload     transfer when
//  scan_in   in   kmsd_in_t   scan_in.valid && scan_in.ready
//  scan_out  out  kmsd_out_t  scan_out.valid && scan_out.ready
//
// one scan tick per clock while scan_in.ready is high: every transfer on scan_in is one tick,
// and its result sits in the output register from the next cycle on
// the key state update and the result register both load in the transfer cycle
// scan_in.ready stays high while the output register is empty or being drained,
// so a stalled scan_out holds exactly one result and blocks further input
// synchronous reset: row counter at the last row, key maps and flag cleared,
// output register empty
`include "keypad_matrix_scan_debounce_defines.svh"

module keypad_matrix_scan_debounce #(
  parameter int NUM_ROWS = kmsd_pkg::NUM_ROWS_DEF,
  parameter int NUM_COLS = kmsd_pkg::NUM_COLS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  kmsd_stream_if.sink   scan_in,
  kmsd_stream_if.source scan_out
);

  localparam int RIDX_W = $clog2(NUM_ROWS);

  logic                      advance;
  logic                      out_valid;
  kmsd_pkg::kmsd_out_t       out_data;
  logic [RIDX_W-1:0]         cur_row;
  kmsd_pkg::kmsd_row_t       row_info;
  kmsd_pkg::kmsd_key_stat_t  key_stat;

  // take a tick whenever the result register is free or empties this cycle
  assign scan_in.ready = !out_valid || scan_out.ready;
  assign advance       = scan_in.valid && scan_in.ready;

  // row counter and drive pattern
  kmsd_row_seq #(
    .NUM_ROWS (NUM_ROWS),
    .RIDX_W   (RIDX_W)
  ) u_row_seq (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .cur_row  (cur_row),
    .row_info (row_info)
  );

  // per-key debounce and latching for the row being scanned
  kmsd_debounce #(
    .NUM_ROWS (NUM_ROWS),
    .NUM_COLS (NUM_COLS),
    .RIDX_W   (RIDX_W)
  ) u_debounce (
    .clk            (clk),
    .rst            (rst),
    .advance        (advance),
    .cur_row        (cur_row),
    .column_sample  (scan_in.data.column_sample),
    .clear_keys     (scan_in.data.clear_keys),
    .clear_activity (scan_in.data.clear_activity),
    .key_stat       (key_stat)
  );

  // result register, valid flag under reset
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (scan_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (advance) begin
      out_data.scanned_row    <= row_info.scanned_row;
      out_data.next_row_drive <= row_info.next_row_drive;
      out_data.new_press      <= key_stat.new_press;
      out_data.pressed_keys   <= key_stat.pressed_keys;
      out_data.any_activity   <= key_stat.any_activity;
    end
  end

  assign scan_out.valid = out_valid;
  assign scan_out.data  = out_data;

  // a taken tick always shows up as a result next cycle
  `KMSD_ASSERT_NEXT(a_tick_gives_result, clk, rst, advance, scan_out.valid)
  // a drained result with no new tick leaves the register empty
  `KMSD_ASSERT_NEXT(a_drain_empties, clk, rst,
    scan_out.valid && scan_out.ready && !advance, !scan_out.valid)
  // a high column 0 this tick sets the activity flag in its own result
  `KMSD_ASSERT_NEXT(a_activity_sets, clk, rst,
    advance && scan_in.data.column_sample[0], scan_out.data.any_activity)

endmodule

/* rtl/kmsd_row_seq.sv */
// row sequencer: row counter, scanned row and next row drive
// depends on kmsd_pkg
module kmsd_row_seq #(
  parameter int NUM_ROWS = kmsd_pkg::NUM_ROWS_DEF,
  parameter int RIDX_W   = $clog2(NUM_ROWS)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  output logic [RIDX_W-1:0] cur_row,
  output kmsd_pkg::kmsd_row_t row_info
);

  localparam logic [RIDX_W-1:0] LAST_ROW = RIDX_W'(NUM_ROWS - 1);

  logic [RIDX_W-1:0] row_index;
  logic [RIDX_W-1:0] after_row;
  logic [31:0]       cur_wide;
  logic [31:0]       after_wide;

  // row scanned by the item at the input
  assign cur_row   = (row_index == LAST_ROW) ? '0 : row_index + 1'b1;
  assign after_row = (cur_row == LAST_ROW) ? '0 : cur_row + 1'b1;

  assign cur_wide   = 32'(cur_row);
  assign after_wide = 32'(after_row);

  always_comb begin
    row_info.scanned_row = cur_wide[kmsd_pkg::ROW_W-1:0];
    for (int i = 0; i < kmsd_pkg::DRIVE_W; i++) begin
      row_info.next_row_drive[i] = (after_wide == 32'(i));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_index <= LAST_ROW;
    end else if (advance) begin
      row_index <= cur_row;
    end
  end

endmodule

/* rtl/kmsd_debounce.sv */
// per-key debounce, press latch and sticky activity flag
// depends on kmsd_pkg
module kmsd_debounce #(
  parameter int NUM_ROWS = kmsd_pkg::NUM_ROWS_DEF,
  parameter int NUM_COLS = kmsd_pkg::NUM_COLS_DEF,
  parameter int RIDX_W   = $clog2(NUM_ROWS)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            advance,
  input  logic [RIDX_W-1:0]               cur_row,
  input  logic [kmsd_pkg::SAMPLE_W-1:0]   column_sample,
  input  logic [kmsd_pkg::KEYMAP_W-1:0]   clear_keys,
  input  logic                            clear_activity,
  output kmsd_pkg::kmsd_key_stat_t        key_stat
);

  localparam int NUM_KEYS  = NUM_ROWS * NUM_COLS;
  localparam int KB        = (NUM_KEYS < kmsd_pkg::MAX_KEYS) ? NUM_KEYS : kmsd_pkg::MAX_KEYS;
  localparam int COLS_USED = (NUM_COLS < kmsd_pkg::SAMPLE_W) ? NUM_COLS : kmsd_pkg::SAMPLE_W;
  localparam logic [kmsd_pkg::SAMPLE_W-1:0] COL_MASK =
    kmsd_pkg::SAMPLE_W'((1 << COLS_USED) - 1);

  logic [KB-1:0] previous_sample, previous_sample_next;
  logic [KB-1:0] stable_level, stable_level_next;
  logic [KB-1:0] press_latch, press_latch_next;
  logic [KB-1:0] rise;
  logic          activity_flag, activity_flag_next;

  for (genvar k = 0; k < KB; k++) begin : g_key
    localparam int KR = k / NUM_COLS;
    localparam int KC = k % NUM_COLS;
    logic cur, sel, same, clr;

    // columns beyond the sample width never read high
    if (KC < kmsd_pkg::SAMPLE_W) begin : g_cur
      assign cur = column_sample[KC];
    end else begin : g_nocur
      assign cur = 1'b0;
    end

    if (k < kmsd_pkg::KEYMAP_W) begin : g_clr
      assign clr = clear_keys[k];
    end else begin : g_noclr
      assign clr = 1'b0;
    end

    assign sel  = (cur_row == RIDX_W'(KR));
    assign same = sel && (cur == previous_sample[k]);
    // stable press after stable release
    assign rise[k] = same && cur && !stable_level[k];

    assign press_latch_next[k]     = (press_latch[k] & ~clr) | rise[k];
    assign stable_level_next[k]    = same ? cur : stable_level[k];
    assign previous_sample_next[k] = sel ? cur : previous_sample[k];
  end

  // clear first, then this tick's activity
  assign activity_flag_next = (activity_flag & ~clear_activity) | (|(column_sample & COL_MASK));

  always_comb begin
    key_stat.new_press    = |rise;
    key_stat.any_activity = activity_flag_next;
    for (int i = 0; i < kmsd_pkg::KEYMAP_W; i++) begin
      key_stat.pressed_keys[i] = (i < KB) ? press_latch_next[i % KB] : 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_sample <= '0;
      stable_level    <= '0;
      press_latch     <= '0;
      activity_flag   <= 1'b0;
    end else if (advance) begin
      previous_sample <= previous_sample_next;
      stable_level    <= stable_level_next;
      press_latch     <= press_latch_next;
      activity_flag   <= activity_flag_next;
    end
  end

endmodule

/* tb/keypad_matrix_scan_debounce_test.sv */
// self-checking bench for the keypad matrix scanner with debounce
// needs kmsd_pkg, kmsd_stream_if and keypad_matrix_scan_debounce from the rtl folder
module keypad_matrix_scan_debounce_test;
  timeunit 1ns;
  timeprecision 1ps;

  // local names for the package items the bench uses
  localparam int SAMPLE_W = kmsd_pkg::SAMPLE_W;
  localparam int KEYMAP_W = kmsd_pkg::KEYMAP_W;
  localparam int ROW_W    = kmsd_pkg::ROW_W;
  localparam int DRIVE_W  = kmsd_pkg::DRIVE_W;
  typedef kmsd_pkg::kmsd_in_t  kmsd_in_t;
  typedef kmsd_pkg::kmsd_out_t kmsd_out_t;

  localparam int ROWS = kmsd_pkg::NUM_ROWS_DEF;
  localparam int COLS = kmsd_pkg::NUM_COLS_DEF;
  localparam int RANDOM_TICKS = 976;
  localparam int CALM_FROM = 826;   // last stretch runs with no idling
  localparam int LONG_STALL_AT = 400;
  localparam int LONG_STALL_LEN = 100;
  localparam int DRAIN_CYCLES = 4;

  // directed ticks, row = tick mod 4
  localparam int DIR_TICKS = 24;
  localparam logic [SAMPLE_W-1:0] DIR_COLS [DIR_TICKS] = '{
    3'd0, 3'd0, 3'd0, 3'd0,   // all released, first visit
    3'd7, 3'd1, 3'd2, 3'd4,   // first press samples
    3'd7, 3'd1, 3'd2, 3'd4,   // second agreeing samples latch
    3'd7, 3'd0, 3'd5, 3'd4,   // held, release start, bounce
    3'd0, 3'd0, 3'd0, 3'd0,   // everything released
    3'd0, 3'd1, 3'd0, 3'd0
  };
  localparam logic [KEYMAP_W-1:0] DIR_CLEAR [DIR_TICKS] = '{
    12'h000, 12'h000, 12'h000, 12'h000,
    12'h000, 12'h000, 12'h000, 12'h000,
    12'hFFF, 12'h000, 12'h000, 12'h000,   // full clear on the latching tick
    12'h000, 12'h000, 12'h000, 12'hFFF,
    12'h000, 12'h000, 12'h000, 12'hAAA,
    12'h000, 12'h555, 12'h000, 12'h000
  };
  localparam logic DIR_CLR_ACT [DIR_TICKS] = '{
    1'b0, 1'b0, 1'b0, 1'b0,
    1'b0, 1'b0, 1'b0, 1'b0,
    1'b1, 1'b0, 1'b0, 1'b0,   // activity this tick beats its own clear
    1'b0, 1'b0, 1'b0, 1'b1,
    1'b1, 1'b0, 1'b0, 1'b0,   // clear with a silent row leaves the flag low
    1'b0, 1'b0, 1'b0, 1'b1
  };

  logic clk;
  logic rst;

  kmsd_stream_if #(.payload_t(kmsd_in_t))  scan_in ();
  kmsd_stream_if #(.payload_t(kmsd_out_t)) scan_out ();

  keypad_matrix_scan_debounce dut (
    .clk      (clk),
    .rst      (rst),
    .scan_in  (scan_in),
    .scan_out (scan_out)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // ticks waiting for the driver, predicted results waiting for the dut
  kmsd_in_t  ticks_to_send [$];
  kmsd_out_t predicted_ticks [$];

  int  mismatches = 0;
  int  results_seen = 0;
  bit  calm = 1'b0;

  // scanner state as the bench sees it, reset values
  logic [ROW_W-1:0]    row_now = ROW_W'(ROWS - 1);
  logic [KEYMAP_W-1:0] last_level = '0;
  logic [KEYMAP_W-1:0] debounced = '0;
  logic [KEYMAP_W-1:0] latched_keys = '0;
  logic                activity_seen = 1'b0;

  // one scan tick: clears act first, then this row's sample updates
  function automatic kmsd_out_t scan_tick(kmsd_in_t item);
    kmsd_out_t res;
    logic [SAMPLE_W-1:0] sample;
    logic [ROW_W-1:0] row;
    logic [ROW_W-1:0] row_after;
    logic cur;
    logic fresh;
    int k;
    sample = item.column_sample & SAMPLE_W'((1 << COLS) - 1);
    row = row_now + 1'b1;        // four rows, so the 2-bit wrap is the row wrap
    row_now = row;
    fresh = 1'b0;
    latched_keys &= ~item.clear_keys;
    if (item.clear_activity) begin
      activity_seen = 1'b0;
    end
    if (sample != '0) begin
      activity_seen = 1'b1;
    end
    for (int c = 0; c < COLS; c++) begin
      k = row * COLS + c;
      cur = sample[c];
      // two agreeing visits make the level stable
      if (cur == last_level[k]) begin
        if (cur && !debounced[k]) begin
          latched_keys[k] = 1'b1;
          fresh = 1'b1;
        end
        debounced[k] = cur;
      end
      last_level[k] = cur;
    end
    row_after = row + 1'b1;
    res.scanned_row = row;
    res.next_row_drive = DRIVE_W'(1) << row_after;
    res.new_press = fresh;
    res.pressed_keys = latched_keys;
    res.any_activity = activity_seen;
    return res;
  endfunction

  // sender: offers queued ticks, idles in random bursts unless calm
  int send_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      scan_in.valid <= 1'b0;
      send_gap <= 0;
    end else if (!scan_in.valid || scan_in.ready) begin
      // slot is free after this edge
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        scan_in.valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        send_gap <= $urandom_range(0, 13);
        scan_in.valid <= 1'b0;
      end else if (ticks_to_send.size() > 0) begin
        scan_in.data <= ticks_to_send.pop_front();
        scan_in.valid <= 1'b1;
      end else begin
        scan_in.valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus one long hold-off so the input backs up
  int  hold_left = 0;
  bit  long_stall_done = 1'b0;
  always @(posedge clk) begin
    if (rst) begin
      scan_out.ready <= 1'b0;
      hold_left <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      scan_out.ready <= 1'b0;
    end else if (!long_stall_done && results_seen >= LONG_STALL_AT) begin
      long_stall_done <= 1'b1;
      hold_left <= LONG_STALL_LEN - 1;
      scan_out.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      hold_left <= $urandom_range(0, 13);
      scan_out.ready <= 1'b0;
    end else begin
      scan_out.ready <= 1'b1;
    end
  end

  // monitor: predict on every input transfer, check every output transfer
  always @(posedge clk) begin
    kmsd_out_t want;
    kmsd_out_t got;
    if (!rst) begin
      if (scan_in.valid && scan_in.ready) begin
        predicted_ticks.push_back(scan_tick(scan_in.data));
      end
      if (scan_out.valid && scan_out.ready) begin
        got = scan_out.data;
        results_seen <= results_seen + 1;
        if (predicted_ticks.size() == 0) begin
          $error("result transfer with no prediction waiting: %h", got);
          mismatches++;
        end else begin
          want = predicted_ticks.pop_front();
          if (got.scanned_row !== want.scanned_row) begin
            $error("scanned_row: expected %0d, got %0d", want.scanned_row, got.scanned_row);
            mismatches++;
          end
          if (got.next_row_drive !== want.next_row_drive) begin
            $error("next_row_drive: expected %b, got %b",
                   want.next_row_drive, got.next_row_drive);
            mismatches++;
          end
          if (got.new_press !== want.new_press) begin
            $error("new_press: expected %b, got %b", want.new_press, got.new_press);
            mismatches++;
          end
          if (got.pressed_keys !== want.pressed_keys) begin
            $error("pressed_keys: expected %h, got %h", want.pressed_keys, got.pressed_keys);
            mismatches++;
          end
          if (got.any_activity !== want.any_activity) begin
            $error("any_activity: expected %b, got %b", want.any_activity, got.any_activity);
            mismatches++;
          end
        end
      end
    end
  end

  // stimulus and end of run
  initial begin
    kmsd_in_t item;
    logic [KEYMAP_W-1:0] held;
    logic [SAMPLE_W-1:0] cols;
    int tick_no;
    int row;
    held = '0;
    tick_no = 0;
    rst = 1'b1;
    scan_in.valid = 1'b0;
    scan_in.data = '0;
    scan_out.ready = 1'b0;

    // directed part: latch, hold, bounce, release and the clear orderings
    for (int i = 0; i < DIR_TICKS; i++) begin
      item.column_sample = DIR_COLS[i];
      item.clear_keys = DIR_CLEAR[i];
      item.clear_activity = DIR_CLR_ACT[i];
      ticks_to_send.push_back(item);
      tick_no++;
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // sender pause: nothing new until every directed result is back
    @(negedge clk);
    while (ticks_to_send.size() != 0 || scan_in.valid || predicted_ticks.size() != 0) begin
      @(negedge clk);
    end

    // random part: physical keys change slowly so presses get through the
    // debounce, with contact bounce and stray clears mixed in
    for (int n = 0; n < RANDOM_TICKS; n++) begin
      if (n == CALM_FROM) begin
        while (ticks_to_send.size() != 0) begin
          @(negedge clk);
        end
        calm = 1'b1;
      end
      row = tick_no % ROWS;
      for (int c = 0; c < COLS; c++) begin
        if ($urandom_range(0, 4) == 0) begin
          held[row * COLS + c] = ~held[row * COLS + c];
        end
      end
      cols = held[row * COLS +: SAMPLE_W];
      if ($urandom_range(0, 9) == 0) begin
        cols ^= SAMPLE_W'($urandom_range(1, 7));    // bounce on this visit
      end
      item.column_sample = cols;
      case ($urandom_range(0, 9))
        6, 7: item.clear_keys = KEYMAP_W'(1) << $urandom_range(0, KEYMAP_W - 1);
        8: item.clear_keys = KEYMAP_W'($urandom());
        9: item.clear_keys = '1;
        default: item.clear_keys = '0;
      endcase
      item.clear_activity = ($urandom_range(0, 7) == 0);
      ticks_to_send.push_back(item);
      tick_no++;
    end

    // drain: all sent, all checked, then a wait for stray results
    while (ticks_to_send.size() != 0 || scan_in.valid || predicted_ticks.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/kmsd_pkg.sv
rtl/kmsd_stream_if.sv
rtl/kmsd_row_seq.sv
rtl/kmsd_debounce.sv
rtl/keypad_matrix_scan_debounce.sv
tb/keypad_matrix_scan_debounce_test.sv
